[src/bde_pkg.sv]
`timescale 1ns / 1ps

package bde_pkg;

    localparam int BAUD_W = 29;
    localparam int WORD_W = 32;
    localparam int MODE_W = 2;
    localparam int EXP_W  = 4;
    localparam int CNT_W  = $clog2(BAUD_W);

    // 12 MHz reference times 32
    localparam logic [BAUD_W-1:0] BASE_RATE = BAUD_W'(384000000);

    localparam logic [MODE_W-1:0] MODE_NORMAL    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ALTERNATE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DIRECT    = 2'd2;

    localparam logic [WORD_W-1:0] NRM_LIMIT   = 32'd512;
    localparam logic [WORD_W-1:0] NRM_TRIM    = 32'd511;
    localparam logic [EXP_W-1:0]  NRM_EXP_MAX = 4'd7;
    localparam logic [WORD_W-1:0] ALT_LIMIT   = 32'd2048;
    localparam logic [WORD_W-1:0] ALT_TRIM    = 32'd2047;
    localparam logic [EXP_W-1:0]  ALT_EXP_MAX = 4'd15;

    localparam logic [7:0] WORD_TAG = 8'h80;

    typedef struct packed {
        logic              start;
        logic [BAUD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [BAUD_W-1:0] quotient;
    } div_rsp_t;

endpackage

[src/bde_divider.sv]
`timescale 1ns / 1ps

// Restoring divider: BASE_RATE / divisor, one quotient bit per cycle.
module bde_divider
(
    input  logic               clk,
    input  logic               rst_n,
    input  bde_pkg::div_req_t  req,
    output bde_pkg::div_rsp_t  rsp
);
    import bde_pkg::*;

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [BAUD_W-1:0]  rem_reg;
    logic [BAUD_W-1:0]  quo_reg;
    logic [BAUD_W-1:0]  dvsr_reg;

    logic [BAUD_W:0]    rem_sh;
    logic [BAUD_W:0]    rem_diff;
    logic               ge;
    logic [BAUD_W-1:0]  rem_next;

    always_comb
    begin
        rem_sh   = {rem_reg, BASE_RATE[cnt_reg]};
        rem_diff = rem_sh - {1'b0, dvsr_reg};
        ge       = (rem_sh >= {1'b0, dvsr_reg});
        rem_next = ge ? rem_diff[BAUD_W-1:0] : rem_sh[BAUD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(BAUD_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= '0;
            dvsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[BAUD_W-2:0], ge};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    a_done_follows_busy : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

    a_cnt_range : assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg <= CNT_W'(BAUD_W - 1)))
        else $error("divider bit counter out of range");

    a_no_restart : assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider restarted while busy");

endmodule

[src/baud_divisor_encoder_unit.sv]
`timescale 1ns / 1ps
// Direct mode: the accepted rate goes through ST_FINISH to the result register.
// Divisor modes run ST_DIV1, ST_SCALE (one mantissa shift per exponent increment) and ST_DIV2,
// both divisions on the single shared bit-serial divider, then ST_FINISH.
// A zero rate skips the first division. ST_FINISH waits while a pending beat is not taken.
// s_tready is high only when idle, so a new rate is taken only once the last one has reached the result register.
// Reset (rst_n low, async): sequencer idle, no result pending, mode normal.

module baud_divisor_encoder_unit
(
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration: divisor_mode
    input  logic                       cfg_wr_en,
    input  logic [bde_pkg::MODE_W-1:0] cfg_wr_data,
    // input stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [31:0]                s_tdata,   // [28:0] req_baud
    // result stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [63:0]                m_tdata    // [31:0] line_rate_word, [60:32] actual_baud
);
    import bde_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV1,
        ST_SCALE,
        ST_DIV2,
        ST_FINISH
    } state_t;

    state_t             state_reg, state_next;
    logic [MODE_W-1:0]  mode_reg;
    logic               alt_reg, alt_next;
    logic               start_reg, start_next;
    logic               m_tvalid_reg, m_tvalid_next;

    logic [BAUD_W-1:0]  baud_reg;
    logic [WORD_W-1:0]  m_reg, m_next;
    logic [EXP_W-1:0]   e_reg, e_next;
    logic [WORD_W-1:0]  word_reg, word_next;
    logic [BAUD_W-1:0]  rate_reg, rate_next;
    logic [63:0]        tdata_reg, tdata_next;

    logic [WORD_W-1:0]  lim;
    logic [WORD_W-1:0]  trim;
    logic [EXP_W-1:0]   emax;
    logic [4:0]         shamt;
    logic               accept;
    logic               out_free;

    div_req_t           div_req;
    div_rsp_t           div_rsp;

    bde_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // divisor for the first pass is the rate, for the second the mantissa
    assign div_req.start   = start_reg;
    assign div_req.divisor = (state_reg == ST_DIV1) ? baud_reg : m_reg[BAUD_W-1:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = tdata_reg;

    // mode 3 falls back to the normal divisor
    assign lim   = alt_reg ? ALT_LIMIT : NRM_LIMIT;
    assign trim  = alt_reg ? ALT_TRIM : NRM_TRIM;
    assign emax  = alt_reg ? ALT_EXP_MAX : NRM_EXP_MAX;
    assign shamt = alt_reg ? {1'b0, e_reg} : {e_reg, 1'b0};

    always_comb
    begin
        state_next    = state_reg;
        alt_next      = alt_reg;
        start_next    = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_next        = m_reg;
        e_next        = e_reg;
        word_next     = word_reg;
        rate_next     = rate_reg;
        tdata_next    = tdata_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    alt_next = (mode_reg == MODE_ALTERNATE);
                    e_next   = '0;
                    if (mode_reg == MODE_DIRECT)
                    begin
                        word_next  = WORD_W'(s_tdata[BAUD_W-1:0]);
                        rate_next  = s_tdata[BAUD_W-1:0];
                        state_next = ST_FINISH;
                    end
                    else if (s_tdata[BAUD_W-1:0] == '0)
                    begin
                        // zero rate: saturated quotient
                        m_next     = '1;
                        state_next = ST_SCALE;
                    end
                    else
                    begin
                        start_next = 1'b1;
                        state_next = ST_DIV1;
                    end
                end
            end
            ST_DIV1:
            begin
                if (div_rsp.done)
                begin
                    m_next     = (div_rsp.quotient == '0) ? WORD_W'(1)
                                                          : WORD_W'(div_rsp.quotient);
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                if (m_reg >= lim)
                begin
                    if (e_reg < emax)
                    begin
                        m_next = alt_reg ? (m_reg >> 1) : (m_reg >> 2);
                        e_next = e_reg + 1'b1;
                    end
                    else
                    begin
                        m_next     = trim;
                        start_next = 1'b1;
                        state_next = ST_DIV2;
                    end
                end
                else
                begin
                    start_next = 1'b1;
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2:
            begin
                if (div_rsp.done)
                begin
                    if (alt_reg)
                        word_next = {WORD_TAG, 7'd0, e_reg[0],
                                     e_reg[3:1], 2'b00, m_reg[10:8], m_reg[7:0]};
                    else
                        word_next = {WORD_TAG, 8'd0,
                                     4'd0, e_reg[2:0], m_reg[8], m_reg[7:0]};
                    rate_next  = div_rsp.quotient >> shamt;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    tdata_next    = {3'd0, rate_reg, word_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            mode_reg     <= MODE_NORMAL;
            alt_reg      <= 1'b0;
            start_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            alt_reg      <= alt_next;
            start_reg    <= start_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en)
                mode_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            baud_reg <= s_tdata[BAUD_W-1:0];
        m_reg     <= m_next;
        e_reg     <= e_next;
        word_reg  <= word_next;
        rate_reg  <= rate_next;
        tdata_reg <= tdata_next;
    end

    a_mantissa_fits : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV2) |-> (m_reg != '0 && m_reg < lim))
        else $error("second divisor outside mantissa range");

    a_exp_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCALE || state_reg == ST_DIV2) |-> (e_reg <= emax))
        else $error("exponent past its limit");

    a_beat_from_finish : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result beat raised outside finish step");

endmodule
